@@ hdl/rq_pkg.sv @@
// Package with the shared types and constants of the ready queue.
`default_nettype none

package rq_pkg;

  localparam int PID_W    = 16;
  localparam int HDL_W    = 16;
  localparam int OP_W     = 3;
  localparam int COUNT_W  = 5;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LIST   = 3'd3,
    OP_CLEAR  = 3'd4
  } rq_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } rq_status_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_SCAN,
    RD_NEXT
  } rq_rd_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RD,
    SRC_HIT
  } rq_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_OUT,
    S_LIST_RD,
    S_LIST_OUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REM_OUT
  } rq_state_t;

  typedef struct packed {
    logic       latch_in;
    rq_rd_t     rd_sel;
    logic       scan_init;
    logic       scan_step;
    logic       shift_wr;
    logic       push_wr;
    logic       pop_adv;
    logic       rem_adv;
    logic       clr;
    logic       hit_latch;
    logic       emit;
    rq_status_t emit_status;
    rq_src_t    emit_src;
    logic       emit_last;
  } rq_cmd_t;

  typedef struct packed {
    rq_op_t op;
    logic   empty;
    logic   full;
    logic   match;
    logic   scan_last;
    logic   out_free;
  } rq_stat_t;

endpackage

`default_nettype wire

@@ hdl/ready_queue_with_pid_removal_top.sv @@
// Top level of the process ready queue with removal by pid.
//
// The input channel carries one request per transfer: in_tuser selects the
// operation (push, pop, remove by pid, list, clear) and in_tdata carries the
// pid and the handle. The output channel returns the results; every request
// produces exactly one result except a list of a non-empty queue, which
// produces one result per held entry, oldest first, with out_tlast on the
// final one. Every result carries the entry count after the operation.
// Requests are handled one at a time through a single entry memory with one
// read and one write port. A list reads the entries one by one from the head;
// a remove by pid reads and compares entries from the head until a match, then
// moves every later entry one place toward the head before its result.
// in_tready is high only when no request is in progress; it returns when the
// last result of a request is loaded.
// Reset empties the queue (head, tail and count to zero) and drops any
// pending result; entry contents are not cleared and need no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// block stalls at its next result until that one is taken.
`default_nettype none

module ready_queue_with_pid_removal_top
  import rq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [IN_DW-1:0]  in_tdata,   // process_id[15:0], process_handle[31:16]
  input  wire  [OP_W-1:0]   in_tuser,   // operation[2:0]
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // status[1:0], out_pid[17:2],
                                        // out_handle[33:18], entry_count[38:34], pad[39]
  output logic              out_tlast   // last
);

  rq_cmd_t  cmd;
  rq_stat_t stat;

  rq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/rq_ctrl.sv @@
// Controller state machine that sequences each queue operation.
`default_nettype none

module rq_ctrl
  import rq_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_tvalid,
  output logic     in_tready,
  input  rq_stat_t stat,
  output rq_cmd_t  cmd
);

  rq_state_t state_r;
  rq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    cmd             = '0;
    cmd.rd_sel      = RD_SCAN;
    cmd.emit_status = ST_OK;
    cmd.emit_src    = SRC_NONE;
    cmd.emit_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.rd_sel = RD_HEAD;
        case (stat.op)
          OP_PUSH: begin
            if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = stat.full ? ST_FULL : ST_OK;
              cmd.push_wr     = !stat.full;
              state_nxt       = S_IDLE;
            end
          end
          OP_POP: begin
            if (!stat.empty) begin
              state_nxt = S_POP_OUT;
            end else if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end
          end
          OP_REMOVE, OP_LIST: begin
            if (!stat.empty) begin
              cmd.scan_init = 1'b1;
              state_nxt     = (stat.op == OP_LIST) ? S_LIST_RD : S_SRCH_RD;
            end else if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end
          end
          OP_CLEAR: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.clr   = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_POP_OUT: begin
        cmd.rd_sel = RD_HEAD;
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = SRC_RD;
          cmd.pop_adv  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LIST_RD: begin
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = SRC_RD;
          cmd.emit_last = stat.scan_last;
          if (stat.scan_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = S_LIST_RD;
          end
        end
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.hit_latch = 1'b1;
          state_nxt     = S_SHIFT_RD;
        end else if (stat.scan_last) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOTFOUND;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        // The entry after the scan position is read here and written back one
        // place toward the head in the following cycle.
        if (stat.scan_last) begin
          state_nxt = S_REM_OUT;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr  = 1'b1;
        cmd.scan_step = 1'b1;
        state_nxt     = S_SHIFT_RD;
      end
      S_REM_OUT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = SRC_HIT;
          cmd.rem_adv  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/rq_dp.sv @@
// Datapath of the ready queue: entry memory, pointers, scan counter and result register.
`default_nettype none

module rq_dp
  import rq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  rq_cmd_t           cmd,
  output rq_stat_t          stat,
  input  wire  [IN_DW-1:0]  in_tdata,
  input  wire  [OP_W-1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = PID_W + HANDLE_WIDTH;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  // Each entry holds the pid in the upper bits and the handle below it.
  logic [DW-1:0] mem [QUEUE_DEPTH];

  logic [AW-1:0]      head_r;
  logic [AW-1:0]      tail_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [AW-1:0]      scan_r;
  logic [CW-1:0]      idx_r;
  rq_op_t             op_r;
  logic [PID_W-1:0]   key_pid_r;
  logic [HANDLE_WIDTH-1:0] key_handle_r;
  logic [DW-1:0]      hit_r;
  logic [DW-1:0]      rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      scan_inc;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic               out_valid_r;
  rq_status_t         out_status_r;
  logic [PID_W-1:0]   out_pid_r;
  logic [HDL_W-1:0]   out_handle_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;
  logic [DW-1:0]      src_entry;
  logic               out_free;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  assign scan_inc = wrap_inc(scan_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_NEXT: rd_addr = scan_inc;
      default: rd_addr = scan_r;
    endcase
  end

  assign wr_en   = cmd.push_wr || cmd.shift_wr;
  assign wr_addr = cmd.push_wr ? tail_r : scan_r;
  assign wr_data = cmd.push_wr ? {key_pid_r, key_handle_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.push_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_adv || cmd.rem_adv) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr) begin
        head_r <= '0;
        tail_r <= '0;
      end else begin
        if (cmd.push_wr) begin
          tail_r <= wrap_inc(tail_r);
        end
        if (cmd.rem_adv) begin
          tail_r <= wrap_dec(tail_r);
        end
        if (cmd.pop_adv) begin
          head_r <= wrap_inc(head_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r         <= rq_op_t'(in_tuser);
      key_pid_r    <= in_tdata[PID_W-1:0];
      key_handle_r <= HANDLE_WIDTH'(in_tdata[IN_DW-1:PID_W]);
    end
    if (cmd.scan_init) begin
      scan_r <= head_r;
      idx_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_inc;
      idx_r  <= idx_r + CW'(1);
    end
    if (cmd.hit_latch) begin
      hit_r <= rd_data_r;
    end
  end

  always_comb begin
    case (cmd.emit_src)
      SRC_RD:  src_entry = rd_data_r;
      SRC_HIT: src_entry = hit_r;
      default: src_entry = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_pid_r    <= src_entry[DW-1:HANDLE_WIDTH];
      out_handle_r <= HDL_W'(src_entry[HANDLE_WIDTH-1:0]);
      out_count_r  <= COUNT_W'(count_nxt);
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_count_r, out_handle_r, out_pid_r, out_status_r};

  assign stat.op        = op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == DEPTH_C);
  assign stat.match     = (rd_data_r[DW-1:HANDLE_WIDTH] == key_pid_r);
  assign stat.scan_last = (idx_r == count_r - CW'(1));
  assign stat.out_free  = out_free;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds the queue depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == DEPTH_C) |-> head_r == tail_r)
    else $error("head and tail disagree for an empty or full queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("a result overwrote one that was not yet taken");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !stat.full)
    else $error("entry written into a full queue");

  a_one_pointer_move: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push_wr, cmd.pop_adv, cmd.rem_adv, cmd.clr}))
    else $error("more than one pointer update in a cycle");

endmodule

`default_nettype wire

@@ sim/ready_queue_with_pid_removal_top_tb.sv @@
// Testbench for the ready queue: directed and random requests checked against a queue model.
`timescale 1ns / 1ps

module ready_queue_with_pid_removal_top_tb;
  import rq_pkg::*;

  localparam int RQ_DEPTH = 16;

  typedef struct packed {
    rq_status_t         status;
    logic [PID_W-1:0]   pid;
    logic [HDL_W-1:0]   hdl;
    logic [COUNT_W-1:0] count;
    logic               last;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  wire               in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;   // process_id[15:0], process_handle[31:16]
  logic [OP_W-1:0]   in_tuser = '0;   // operation[2:0]
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  wire  [OUT_DW-1:0] out_tdata;       // status[1:0], out_pid[17:2], out_handle[33:18],
                                      // entry_count[38:34], pad[39]
  wire               out_tlast;

  // Model of the queue contents, updated at each accepted request.
  logic [PID_W-1:0] model_pid [RQ_DEPTH];
  logic [HDL_W-1:0] model_hdl [RQ_DEPTH];
  int model_head = 0;
  int model_tail = 0;
  int model_count = 0;

  queue_result_t pending_results [$];
  queue_result_t oldest_result;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit fill_mode = 1'b1;

  ready_queue_with_pid_removal_top #(
    .QUEUE_DEPTH (RQ_DEPTH),
    .HANDLE_WIDTH(HDL_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("ready_queue_with_pid_removal_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic queue_result_t make_result(rq_status_t st, logic [PID_W-1:0] pid,
                                                logic [HDL_W-1:0] hdl, logic fin);
    queue_result_t r;
    r.status = st;
    r.pid    = pid;
    r.hdl    = hdl;
    r.count  = COUNT_W'(model_count);
    r.last   = fin;
    return r;
  endfunction

  // Applies one request to the queue model and queues the results it causes.
  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                                input logic [HDL_W-1:0] hdl);
    int found;
    int pos;
    int dst;
    int src;
    logic [PID_W-1:0] hit_pid;
    logic [HDL_W-1:0] hit_hdl;
    case (op)
      OP_PUSH: begin
        if (model_count >= RQ_DEPTH) begin
          pending_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
        end else begin
          model_pid[model_tail] = pid;
          model_hdl[model_tail] = hdl;
          model_tail = (model_tail + 1) % RQ_DEPTH;
          model_count++;
          pending_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          pos = model_head;
          model_head = (model_head + 1) % RQ_DEPTH;
          model_count--;
          pending_results.push_back(make_result(ST_OK, model_pid[pos], model_hdl[pos], 1'b1));
        end
      end
      OP_REMOVE: begin
        if (model_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          found = model_count;
          for (int i = 0; i < model_count; i++) begin
            if (found == model_count && model_pid[(model_head + i) % RQ_DEPTH] == pid) begin
              found = i;
            end
          end
          if (found == model_count) begin
            pending_results.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
          end else begin
            pos = (model_head + found) % RQ_DEPTH;
            hit_pid = model_pid[pos];
            hit_hdl = model_hdl[pos];
            // Later entries move one place toward the head to close the gap.
            for (int i = found; i + 1 < model_count; i++) begin
              dst = (model_head + i) % RQ_DEPTH;
              src = (model_head + i + 1) % RQ_DEPTH;
              model_pid[dst] = model_pid[src];
              model_hdl[dst] = model_hdl[src];
            end
            model_tail = (model_tail + RQ_DEPTH - 1) % RQ_DEPTH;
            model_count--;
            pending_results.push_back(make_result(ST_OK, hit_pid, hit_hdl, 1'b1));
          end
        end
      end
      OP_LIST: begin
        if (model_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < model_count; i++) begin
            pos = (model_head + i) % RQ_DEPTH;
            pending_results.push_back(make_result(ST_OK, model_pid[pos], model_hdl[pos],
                                                  i + 1 == model_count));
          end
        end
      end
      OP_CLEAR: begin
        model_head = 0;
        model_tail = 0;
        model_count = 0;
        pending_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
      end
      default: begin
        pending_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
      end
    endcase
  endtask

  // Sends one request and updates the model at the edge where it is taken.
  // The valid stays high after acceptance; the next call sets a new request or a drain lowers it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                              input logic [HDL_W-1:0] hdl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {hdl, pid};
    do @(posedge clk); while (!in_tready);
    apply_queue_op(op, pid, hdl);
  endtask

  task automatic wait_results_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: tdata 0x%0h", out_tdata);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", oldest_result.status, out_tdata[1:0]);
        check_field("out_pid", oldest_result.pid, out_tdata[17:2]);
        check_field("out_handle", oldest_result.hdl, out_tdata[33:18]);
        check_field("entry_count", oldest_result.count, out_tdata[38:34]);
        check_field("last", oldest_result.last, out_tlast);
      end
    end
  end

  task automatic test_empty_queue;
    send_request(OP_POP, 16'h0001, 16'h0001);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
    send_request(OP_LIST, 16'hFFFF, 16'hFFFF);
    send_request(OP_LIST + 3'd2, 16'hA5A5, 16'h5A5A);
  endtask

  task automatic test_fill_to_full;
    logic [PID_W-1:0] pid;
    logic [HDL_W-1:0] hdl;
    for (int i = 0; i < RQ_DEPTH; i++) begin
      pid = (i == RQ_DEPTH - 1) ? 16'hFFFF : PID_W'(i % 6);
      hdl = (i == 0) ? 16'hFFFF : (i == RQ_DEPTH - 1) ? 16'h0000 : HDL_W'($urandom());
      send_request(OP_PUSH, pid, hdl);
    end
    send_request(OP_PUSH, 16'h1234, 16'h4321);
  endtask

  task automatic test_remove_and_list;
    // Pid 3 is held twice; only the older copy goes.
    send_request(OP_REMOVE, 16'h0003, 16'h0000);
    send_request(OP_REMOVE, 16'h4242, 16'hFFFF);
    send_request(OP_POP, 16'h0000, 16'h0000);
    send_request(OP_LIST, 16'h0000, 16'h0000);
    send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
    int roll;
    int pick;
    logic [OP_W-1:0] op;
    logic [PID_W-1:0] pid;
    logic [HDL_W-1:0] hdl;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(29) == 0 ||
          (fill_mode && model_count == RQ_DEPTH && $urandom_range(3) == 0) ||
          (!fill_mode && model_count == 0 && $urandom_range(3) == 0)) begin
        fill_mode = !fill_mode;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = OP_W'($urandom_range(7, 5));
      end else if (roll < 4 || (!fill_mode && roll < 6)) begin
        op = OP_CLEAR;
      end else if (roll < 13) begin
        op = OP_LIST;
      end else if (roll < 60) begin
        op = fill_mode ? OP_PUSH : OP_POP;
      end else if (roll < 80) begin
        op = OP_REMOVE;
      end else begin
        op = fill_mode ? OP_POP : OP_PUSH;
      end
      pick = $urandom_range(9);
      if (pick < 6) begin
        pid = PID_W'($urandom_range(7));
      end else if (pick < 8) begin
        pid = PID_W'($urandom());
      end else begin
        pid = (pick == 8) ? 16'h0000 : 16'hFFFF;
      end
      // Removals mostly target a pid that is actually held.
      if (op == OP_REMOVE && model_count > 0 && $urandom_range(9) < 7) begin
        pid = model_pid[(model_head + $urandom_range(model_count - 1)) % RQ_DEPTH];
      end
      hdl = HDL_W'($urandom());
      send_request(op, pid, hdl);
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 82;
    test_empty_queue();
    test_fill_to_full();
    test_remove_and_list();
    wait_results_drained();
    test_random_traffic(117, 34, 82);
    test_random_traffic(117, 82, 34);
    test_random_traffic(116, 0, 0);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ready_queue_with_pid_removal_top_tb: clean");
    end else begin
      $display("ready_queue_with_pid_removal_top_tb: errors");
    end
    $finish;
  end

endmodule
